// ----- hdl/rpah_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the region pixel adjuster with intensity histogram.
package rpah_pkg;

    localparam int MAX_DIMENSION_DEF = 4096;

    localparam int PIX_W      = 8;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 8;
    localparam int OFS_W      = 9;
    localparam int DIM_REG_W  = 13;
    localparam int COUNT_W    = 25;
    localparam int BIN_W      = 3;
    localparam int NUM_BINS   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int PROD_W = PIX_W + GAIN_W;
    localparam int SUM3_W = PIX_W + 2;

    localparam logic [PIX_W-1:0]   BYTE_MAX  = 8'd255;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [BIN_W-1:0]   LAST_BIN  = 3'd7;

    localparam int CHANNELS     = 3;
    localparam int BIN_SPAN     = 32;
    // floor(s / 3) equals (s * 683) >> 11 for every sum of three bytes.
    localparam int RECIP3       = 683;
    localparam int RECIP3_SHIFT = 11;

    localparam logic [GAIN_W-1:0]    GAIN_RESET = 16'd256;
    localparam logic [OFS_W-1:0]     OFS_RESET  = 9'd0;
    localparam logic [DIM_REG_W-1:0] DIM_RESET  = 13'd512;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE_GAIN        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS        = 2'd3;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_BIN   = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] blue_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] red_in;
    } in_item_t;

    typedef struct packed {
        logic               item_kind;
        logic [PIX_W-1:0]   blue_out;
        logic [PIX_W-1:0]   green_out;
        logic [PIX_W-1:0]   red_out;
        logic [BIN_W-1:0]   bin_index;
        logic [COUNT_W-1:0] bin_count;
        logic               last_item;
    } out_item_t;

    typedef struct packed {
        logic upper;
        logic left;
        logic lower;
    } region_t;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        region_t          region;
        logic             frame_end;
    } pix_t;

endpackage

// ----- hdl/rpah_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module rpah_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/rpah_pixel_pipe.sv -----
`timescale 1ns / 1ps
// Three-stage pixel arithmetic: gain, red-minus-grey and offset, with per-stage flow control.
module rpah_pixel_pipe (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  rpah_pkg::pix_t                        item,
    input  logic [rpah_pkg::GAIN_W-1:0]           scale_gain,
    input  logic signed [rpah_pkg::OFS_W-1:0]     brightness_offset,
    output logic                                  s3_valid,
    input  logic                                  s3_ready,
    output rpah_pkg::pix_t                        s3_item
);

    import rpah_pkg::*;

    localparam int GREY_PROD_W = 2 * SUM3_W;
    localparam int OFS_SUM_W   = PIX_W + 2;

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic s1_move, s2_move, s3_move, item_fire;

    pix_t s1_pix_reg;
    pix_t s2_pix_reg, s2_pix_next;
    pix_t s3_pix_reg, s3_pix_next;
    logic [SUM3_W-1:0] s2_sum_reg, s2_sum_next;

    logic [GREY_PROD_W-1:0] grey_prod;
    logic [PIX_W-1:0]       grey;
    logic [PIX_W:0]         red_diff;
    logic [PIX_W-1:0]       red_less_grey;

    function automatic logic [PIX_W-1:0] apply_gain(input logic [PIX_W-1:0]  c,
                                                    input logic [GAIN_W-1:0] g);
        logic [PROD_W-1:0] p;
        p = PROD_W'(c) * PROD_W'(g);
        if (|p[PROD_W-1:GAIN_FRAC+PIX_W])
        begin
            return BYTE_MAX;
        end
        return p[GAIN_FRAC +: PIX_W];
    endfunction

    function automatic logic [PIX_W-1:0] add_offset(input logic [PIX_W-1:0]        c,
                                                    input logic signed [OFS_W-1:0] o);
        logic signed [OFS_SUM_W-1:0] t;
        t = $signed({2'b00, c}) + OFS_SUM_W'(o);
        if (t < 0)
        begin
            return '0;
        end
        if (t > $signed(OFS_SUM_W'(BYTE_MAX)))
        begin
            return BYTE_MAX;
        end
        return t[PIX_W-1:0];
    endfunction

    // A stage moves on when the stage after it is empty or moving itself.
    assign s3_move    = s3_valid_reg && s3_ready;
    assign s2_move    = s2_valid_reg && (!s3_valid_reg || s3_move);
    assign s1_move    = s1_valid_reg && (!s2_valid_reg || s2_move);
    assign item_ready = !s1_valid_reg || s1_move;
    assign item_fire  = item_valid && item_ready;

    always_comb
    begin
        s1_valid_next = item_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        s2_valid_next = s1_move   ? 1'b1 : (s2_move ? 1'b0 : s2_valid_reg);
        s3_valid_next = s2_move   ? 1'b1 : (s3_move ? 1'b0 : s3_valid_reg);
    end

    always_comb
    begin
        s2_pix_next = s1_pix_reg;
        if (s1_pix_reg.region.upper)
        begin
            s2_pix_next.blue  = apply_gain(s1_pix_reg.blue, scale_gain);
            s2_pix_next.green = apply_gain(s1_pix_reg.green, scale_gain);
            s2_pix_next.red   = apply_gain(s1_pix_reg.red, scale_gain);
        end
        s2_sum_next = SUM3_W'(s2_pix_next.blue) + SUM3_W'(s2_pix_next.green)
                    + SUM3_W'(s2_pix_next.red);
    end

    always_comb
    begin
        grey_prod     = GREY_PROD_W'(s2_sum_reg) * GREY_PROD_W'(RECIP3);
        grey          = grey_prod[RECIP3_SHIFT +: PIX_W];
        red_diff      = {1'b0, s2_pix_reg.red} - {1'b0, grey};
        red_less_grey = red_diff[PIX_W] ? '0 : red_diff[PIX_W-1:0];

        s3_pix_next = s2_pix_reg;
        if (s2_pix_reg.region.left)
        begin
            s3_pix_next.blue  = red_less_grey;
            s3_pix_next.green = red_less_grey;
            s3_pix_next.red   = red_less_grey;
        end
        if (s2_pix_reg.region.lower)
        begin
            s3_pix_next.blue  = add_offset(s3_pix_next.blue, brightness_offset);
            s3_pix_next.green = add_offset(s3_pix_next.green, brightness_offset);
            s3_pix_next.red   = add_offset(s3_pix_next.red, brightness_offset);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            s1_pix_reg <= item;
        end
        if (s1_move)
        begin
            s2_pix_reg <= s2_pix_next;
            s2_sum_reg <= s2_sum_next;
        end
        if (s2_move)
        begin
            s3_pix_reg <= s3_pix_next;
        end
    end

    assign s3_valid = s3_valid_reg;
    assign s3_item  = s3_pix_reg;

endmodule

// ----- hdl/rpah_hist.sv -----
`timescale 1ns / 1ps
// Histogram counters in RAM with read-modify-write, frame-end report sequencer and output register.
module rpah_hist (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s3_valid,
    output logic                s3_ready,
    input  rpah_pkg::pix_t      s3_item,
    output logic                out_valid,
    input  logic                out_stall,
    output rpah_pkg::out_item_t out_data
);

    import rpah_pkg::*;

    typedef enum logic [2:0] {
        ST_PIXEL     = 3'b001,
        ST_DUMP_READ = 3'b010,
        ST_DUMP_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [BIN_W-1:0] dump_idx_reg, dump_idx_next;

    logic out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    logic upd_valid_reg;
    logic [BIN_W-1:0] upd_bin_reg;

    logic [NUM_BINS-1:0] bin_valid_reg, bin_valid_next;
    logic rd_valid_reg, rd_valid_next;
    logic fwd_valid_reg, fwd_valid_next;
    logic [COUNT_W-1:0] fwd_data_reg, fwd_data_next;

    logic out_free, pix_load, dump_emit;
    logic [SUM3_W-1:0] pix_sum;
    logic [BIN_W-1:0] pix_bin;

    logic rd_en, wr_en;
    logic [BIN_W-1:0] rd_addr;
    logic [COUNT_W-1:0] ram_rdata, count_eff, count_inc;

    function automatic logic [BIN_W-1:0] bin_of(input logic [SUM3_W-1:0] s);
        logic [BIN_W-1:0] n;
        n = '0;
        for (int k = 1; k < NUM_BINS; k++)
        begin
            if (s >= SUM3_W'(k * CHANNELS * BIN_SPAN))
            begin
                n = n + BIN_W'(1);
            end
        end
        return n;
    endfunction

    assign out_free  = !out_valid_reg || !out_stall;
    assign s3_ready  = (state_reg == ST_PIXEL) && out_free;
    assign pix_load  = s3_valid && s3_ready;
    assign dump_emit = (state_reg == ST_DUMP_EMIT) && out_free;

    assign pix_sum = SUM3_W'(s3_item.blue) + SUM3_W'(s3_item.green) + SUM3_W'(s3_item.red);
    assign pix_bin = bin_of(pix_sum);

    // The report sequencer reads the next bin while the current one is handed out.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = pix_bin;
        if (pix_load)
        begin
            rd_en = 1'b1;
        end
        else if (state_reg == ST_DUMP_READ)
        begin
            rd_en   = 1'b1;
            rd_addr = dump_idx_reg;
        end
        else if (dump_emit && dump_idx_reg != LAST_BIN)
        begin
            rd_en   = 1'b1;
            rd_addr = dump_idx_reg + BIN_W'(1);
        end
    end

    // A write in the cycle of the read is not seen by the RAM, so it is forwarded.
    assign wr_en     = upd_valid_reg;
    assign count_eff = fwd_valid_reg ? fwd_data_reg : (rd_valid_reg ? ram_rdata : '0);
    assign count_inc = (count_eff == COUNT_MAX) ? COUNT_MAX : count_eff + COUNT_W'(1);

    always_comb
    begin
        fwd_valid_next = fwd_valid_reg;
        fwd_data_next  = fwd_data_reg;
        rd_valid_next  = rd_valid_reg;
        if (rd_en)
        begin
            fwd_valid_next = wr_en && (upd_bin_reg == rd_addr);
            fwd_data_next  = count_inc;
            rd_valid_next  = bin_valid_reg[rd_addr];
        end

        bin_valid_next = bin_valid_reg;
        if (wr_en)
        begin
            bin_valid_next[upd_bin_reg] = 1'b1;
        end
        if (dump_emit)
        begin
            bin_valid_next[dump_idx_reg] = 1'b0;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        dump_idx_next = dump_idx_reg;
        unique case (state_reg)
            ST_PIXEL:
            begin
                if (pix_load && s3_item.frame_end)
                begin
                    state_next    = ST_DUMP_READ;
                    dump_idx_next = '0;
                end
            end
            ST_DUMP_READ:
            begin
                state_next = ST_DUMP_EMIT;
            end
            ST_DUMP_EMIT:
            begin
                if (dump_emit)
                begin
                    if (dump_idx_reg == LAST_BIN)
                    begin
                        state_next = ST_PIXEL;
                    end
                    else
                    begin
                        dump_idx_next = dump_idx_reg + BIN_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_PIXEL;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (pix_load)
        begin
            out_valid_next          = 1'b1;
            out_data_next.item_kind = KIND_PIXEL;
            out_data_next.blue_out  = s3_item.blue;
            out_data_next.green_out = s3_item.green;
            out_data_next.red_out   = s3_item.red;
            out_data_next.bin_index = '0;
            out_data_next.bin_count = '0;
            out_data_next.last_item = !s3_item.frame_end;
        end
        else if (dump_emit)
        begin
            out_valid_next          = 1'b1;
            out_data_next.item_kind = KIND_BIN;
            out_data_next.blue_out  = '0;
            out_data_next.green_out = '0;
            out_data_next.red_out   = '0;
            out_data_next.bin_index = dump_idx_reg;
            out_data_next.bin_count = count_eff;
            out_data_next.last_item = (dump_idx_reg == LAST_BIN);
        end
    end

    rpah_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_BINS)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (upd_bin_reg),
        .wr_data (count_inc),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_PIXEL;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            upd_valid_reg <= 1'b0;
            bin_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
            upd_valid_reg <= pix_load;
            bin_valid_reg <= bin_valid_next;
            rd_valid_reg  <= rd_valid_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        fwd_data_reg <= fwd_data_next;
        if (pix_load)
        begin
            upd_bin_reg <= pix_bin;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- hdl/region_pixel_adjust_histogram.sv -----
`timescale 1ns / 1ps
// An accepted pixel passes the three arithmetic stages, then the output register.
// Throughput: one pixel per cycle while out_stall is low and no bin report is under way,
// set by the three arithmetic stages and the single counter RAM read and written once per
// pixel. At the end of a frame the eight bin reports follow from the RAM after a read
// state, one per cycle with out_stall low; input stalls once the pipe behind them fills.
// Reset (rst_n, asynchronous) restores the register defaults, the position and empty bins.
module region_pixel_adjust_histogram #(
    parameter int MAX_DIMENSION = rpah_pkg::MAX_DIMENSION_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  rpah_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output rpah_pkg::out_item_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rpah_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpah_pkg::CFG_DATA_W-1:0] cfg_data
);

    import rpah_pkg::*;

    localparam int POS_W = $clog2(MAX_DIMENSION);
    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
    localparam int SUM_W = POS_W + 1;

    logic [GAIN_W-1:0]        scale_gain_reg;
    logic signed [OFS_W-1:0]  brightness_offset_reg;
    logic [DIM_REG_W-1:0]     image_rows_reg;
    logic [DIM_REG_W-1:0]     image_cols_reg;

    logic [POS_W-1:0] row_reg, row_next;
    logic [POS_W-1:0] col_reg, col_next;

    logic [DIM_W-1:0] rows_dim, cols_dim;
    logic [SUM_W-1:0] pos_sum, row_ext, col_ext, rows_ext, cols_ext;
    logic row_end, frame_end, accept, pipe_ready;
    pix_t item;

    logic s3_valid, s3_ready;
    pix_t s3_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_gain_reg        <= GAIN_RESET;
            brightness_offset_reg <= OFS_RESET;
            image_rows_reg        <= DIM_RESET;
            image_cols_reg        <= DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SCALE_GAIN:        scale_gain_reg        <= cfg_data[GAIN_W-1:0];
                REG_BRIGHTNESS_OFFSET: brightness_offset_reg <= cfg_data[OFS_W-1:0];
                REG_IMAGE_ROWS:        image_rows_reg        <= cfg_data[DIM_REG_W-1:0];
                REG_IMAGE_COLS:        image_cols_reg        <= cfg_data[DIM_REG_W-1:0];
                default:               ;
            endcase
        end
    end

    // Frame dimensions are held to one up to the largest supported size.
    always_comb
    begin
        if (image_rows_reg == '0)
        begin
            rows_dim = DIM_W'(1);
        end
        else if (32'(image_rows_reg) > 32'(MAX_DIMENSION))
        begin
            rows_dim = DIM_W'(MAX_DIMENSION);
        end
        else
        begin
            rows_dim = DIM_W'(image_rows_reg);
        end

        if (image_cols_reg == '0)
        begin
            cols_dim = DIM_W'(1);
        end
        else if (32'(image_cols_reg) > 32'(MAX_DIMENSION))
        begin
            cols_dim = DIM_W'(MAX_DIMENSION);
        end
        else
        begin
            cols_dim = DIM_W'(image_cols_reg);
        end
    end

    // The diagonals split the frame: row + col against the row and column counts.
    always_comb
    begin
        row_ext  = SUM_W'(row_reg);
        col_ext  = SUM_W'(col_reg);
        rows_ext = SUM_W'(rows_dim);
        cols_ext = SUM_W'(cols_dim);
        pos_sum  = row_ext + col_ext;

        row_end   = col_ext >= cols_ext - SUM_W'(1);
        frame_end = row_end && (row_ext >= rows_ext - SUM_W'(1));

        item.blue         = in_data.blue_in;
        item.green        = in_data.green_in;
        item.red          = in_data.red_in;
        item.region.upper = (col_ext >= row_ext) && (pos_sum <= rows_ext);
        item.region.left  = (row_ext > col_ext) && (pos_sum < cols_ext);
        item.region.lower = (row_ext >= col_ext) && (pos_sum >= rows_ext);
        item.frame_end    = frame_end;
    end

    assign accept   = in_valid && pipe_ready;
    assign in_stall = !pipe_ready;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (row_end)
            begin
                row_next = row_reg + POS_W'(1);
                col_next = '0;
            end
            else
            begin
                col_next = col_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    rpah_pixel_pipe u_pixel_pipe (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (in_valid),
        .item_ready        (pipe_ready),
        .item              (item),
        .scale_gain        (scale_gain_reg),
        .brightness_offset (brightness_offset_reg),
        .s3_valid          (s3_valid),
        .s3_ready          (s3_ready),
        .s3_item           (s3_item)
    );

    rpah_hist u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .s3_valid  (s3_valid),
        .s3_ready  (s3_ready),
        .s3_item   (s3_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ----- hdl/rpah_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the region pixel adjuster, bound to the top level.
module rpah_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input rpah_pkg::out_item_t out_data
);

    import rpah_pkg::*;

    // A stalled result request keeps its valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output valid dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("output payload changed while stalled");

    // Bin reports run without a pixel in between until the last bin.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.item_kind == KIND_BIN && !out_data.last_item
        |=> !out_valid || out_data.item_kind == KIND_BIN)
        else $error("pixel interleaved with bin reports");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.item_kind == KIND_BIN
        |-> out_data.last_item == (out_data.bin_index == LAST_BIN))
        else $error("bin report last flag does not match the bin");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.item_kind == KIND_PIXEL
        |-> out_data.bin_index == '0 && out_data.bin_count == '0)
        else $error("pixel result carries histogram fields");

endmodule

bind region_pixel_adjust_histogram rpah_checker u_rpah_checker (.*);
